// ===== rtl/core/mha_pkg.sv =====
// Shared widths, constants, state types and the arctangent table of the heading block.
package mha_pkg;

   localparam int InWidth       = 16;
   localparam int HeadWidth     = 10;
   localparam int RefWidth      = 9;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 9;

   localparam int AVERAGE_COUNT = 10;
   localparam int CORDIC_STEPS  = 16;
   localparam int TableLen      = 24;

   localparam int DigitWidth    = 8;
   localparam int CordicWidth   = 40;
   localparam int NumDigits     = CordicWidth / DigitWidth;
   localparam int DigitCntWidth = $clog2(NumDigits);
   localparam int StepWidth     = $clog2(TableLen);
   localparam int IdxWidth      = $clog2(CordicWidth);
   localparam int AngleFrac     = 24;
   localparam int InShift       = 14;
   localparam int ExtWidth      = InWidth + 1;

   localparam int DirWidth      = 11;
   localparam int SumWidth      = 14;
   localparam int QuotWidth     = 13;
   localparam int CountWidth    = 4;
   localparam int QuotCntWidth  = $clog2(QuotWidth);
   localparam int FullCircle    = 360;
   localparam int HalfCircle    = 180;

   localparam int AtanZero = 755357654;

   localparam logic [CordicWidth-1:0] QuarterTurn    = CordicWidth'(2 * AtanZero);
   localparam logic [CordicWidth-1:0] NegQuarterTurn = -QuarterTurn;
   localparam logic [CordicWidth-1:0] HalfTurnScaled = CordicWidth'(HalfCircle) << AngleFrac;

   localparam logic [CsrIndexWidth-1:0] REG_REFERENCE_HEADING = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] REG_REFERENCE_ENABLED = CsrIndexWidth'(1);

   typedef enum logic [1:0] {
      CORDIC_IDLE,
      CORDIC_RUN,
      CORDIC_DONE
   } cordic_state_type;

   typedef enum logic [1:0] {
      AVG_IDLE,
      AVG_DIVIDE,
      AVG_HOLD
   } avg_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_status_type;

   typedef struct packed {
      logic busy;
      logic result_valid;
   } avg_status_type;

   function automatic logic [CordicWidth-1:0] atan_entry(input logic [StepWidth-1:0] step);
      logic [CordicWidth-1:0] result;
      case (step)
         5'd0:    result = CordicWidth'(AtanZero);
         5'd1:    result = CordicWidth'(445913661);
         5'd2:    result = CordicWidth'(235608532);
         5'd3:    result = CordicWidth'(119598570);
         5'd4:    result = CordicWidth'(60031368);
         5'd5:    result = CordicWidth'(30044948);
         5'd6:    result = CordicWidth'(15026140);
         5'd7:    result = CordicWidth'(7513529);
         5'd8:    result = CordicWidth'(3756822);
         5'd9:    result = CordicWidth'(1878418);
         5'd10:   result = CordicWidth'(939210);
         5'd11:   result = CordicWidth'(469605);
         5'd12:   result = CordicWidth'(234803);
         5'd13:   result = CordicWidth'(117401);
         5'd14:   result = CordicWidth'(58701);
         5'd15:   result = CordicWidth'(29350);
         5'd16:   result = CordicWidth'(14675);
         5'd17:   result = CordicWidth'(7338);
         5'd18:   result = CordicWidth'(3669);
         5'd19:   result = CordicWidth'(1834);
         5'd20:   result = CordicWidth'(917);
         5'd21:   result = CordicWidth'(459);
         5'd22:   result = CordicWidth'(229);
         5'd23:   result = CordicWidth'(115);
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

// ===== rtl/core/magnetometer_heading_average.sv =====
// Top level of the magnetometer heading averager: request, result and register ports.
//
// Each request carries one X/Y magnetometer sample. The block turns it into a whole-degree
// heading with a vectoring CORDIC whose three 40-bit datapaths move through 8-bit serial
// adders one digit at a time, taking no new sample until the last is through; a sample
// with Y equal to zero skips the iterations. The optional reference heading is subtracted
// and folded to -179..180, and every AVERAGE_COUNT headings are summed and divided by a
// bit-serial restoring divider. The averaged heading waits in an output register; new
// requests are taken while it waits. Register writes belong in idle periods.
module magnetometer_heading_average
   import mha_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [2*InWidth-1:0]     req_tdata,   // mag_x [15:0], mag_y [31:16]

   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // heading_deg [9:0], zero [15:10]

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   localparam int RspPadWidth = 16 - HeadWidth;

   logic [RefWidth-1:0]         reference_heading_ff;
   logic                        reference_enabled_ff;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic signed [HeadWidth-1:0] rsp_heading_ff;

   cordic_status_type           cordic_status;
   avg_status_type              avg_status;
   logic signed [HeadWidth-1:0] angle;
   logic signed [HeadWidth-1:0] heading;
   logic                        start, out_free, rsp_load;

   assign csr_ready  = 1'b1;
   assign req_tready = !cordic_status.busy && !avg_status.busy;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load   = avg_status.result_valid && out_free;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {RspPadWidth'(0), rsp_heading_ff};

   mha_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .mag_x  (signed'(req_tdata[InWidth-1:0])),
      .mag_y  (signed'(req_tdata[2*InWidth-1:InWidth])),
      .status (cordic_status),
      .angle  (angle)
   );

   mha_average u_average (
      .clock             (clock),
      .reset             (reset),
      .angle_valid       (cordic_status.done),
      .angle             (angle),
      .reference_heading (reference_heading_ff),
      .reference_enabled (reference_enabled_ff),
      .out_free          (out_free),
      .status            (avg_status),
      .heading           (heading)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_heading_ff <= '0;
         reference_enabled_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_REFERENCE_HEADING: reference_heading_ff <= csr_data[RefWidth-1:0];
            REG_REFERENCE_ENABLED: reference_enabled_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // hold the result until the response is taken
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_heading_ff <= heading;
      end
   end

endmodule

// ===== rtl/core/mha_cordic.sv =====
// Digit-serial vectoring CORDIC that turns one X/Y sample into a whole-degree angle.
module mha_cordic
   import mha_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [InWidth-1:0]   mag_x,
   input  logic signed [InWidth-1:0]   mag_y,
   output cordic_status_type           status,
   output logic signed [HeadWidth-1:0] angle
);

   cordic_state_type state_ff, state_in;

   logic [CordicWidth-1:0]   px_ff, px_in;
   logic [CordicWidth-1:0]   py_ff, py_in;
   logic [CordicWidth-1:0]   z_ff, z_in;
   logic                     cx_ff, cy_ff, cz_ff;
   logic                     sx_ff, sy_ff;
   logic [StepWidth-1:0]     step_ff, step_in;
   logic [DigitCntWidth-1:0] digit_ff, digit_in;

   logic load, advance;
   logic first, last_digit, last_step;
   logic sign_x, sign_y;
   logic cin_x, cin_y, cin_z;
   logic [DigitWidth-1:0]  dx, dy, tab_digit;
   logic [CordicWidth-1:0] tab_word;
   logic [DigitWidth:0]    sum_x, sum_y, sum_z;

   logic                       y_zero;
   logic signed [ExtWidth-1:0] x_ext, y_ext, x_neg, y_neg;
   logic [CordicWidth-1:0]     px_load, py_load, z_load;
   logic                       round_up;

   function automatic logic [DigitWidth-1:0] shifted_digit(
      input logic [CordicWidth-1:0]   word,
      input logic                     sign,
      input logic [StepWidth-1:0]     step,
      input logic [DigitCntWidth-1:0] digit
   );
      logic [DigitWidth-1:0] result;
      logic [IdxWidth-1:0]   pos;
      logic [IdxWidth:0]     reach;
      for (int j = 0; j < DigitWidth; j++) begin
         pos       = IdxWidth'(step) + IdxWidth'(j);
         reach     = {1'b0, pos} + (IdxWidth+1)'(digit) * (IdxWidth+1)'(DigitWidth);
         result[j] = (reach < (IdxWidth+1)'(CordicWidth)) ? word[pos] : sign;
      end
      return result;
   endfunction

   function automatic logic [CordicWidth-1:0] scale_in(input logic signed [ExtWidth-1:0] v);
      return CordicWidth'(v) << InShift;
   endfunction

   // prerotate into the right half plane
   always_comb begin
      y_zero = (mag_y == '0);
      x_ext  = ExtWidth'(mag_x);
      y_ext  = ExtWidth'(mag_y);
      x_neg  = -x_ext;
      y_neg  = -y_ext;
      if (y_zero) begin
         px_load = '0;
         py_load = '0;
         z_load  = mag_x[InWidth-1] ? HalfTurnScaled : '0;
      end else if (!mag_y[InWidth-1]) begin
         px_load = scale_in(y_ext);
         py_load = scale_in(x_ext);
         z_load  = '0;
      end else if (!mag_x[InWidth-1]) begin
         px_load = scale_in(x_ext);
         py_load = scale_in(y_neg);
         z_load  = QuarterTurn;
      end else begin
         px_load = scale_in(x_neg);
         py_load = scale_in(y_ext);
         z_load  = NegQuarterTurn;
      end
   end

   // one digit of the three serial adders
   always_comb begin
      first      = (digit_ff == '0);
      last_digit = (digit_ff == DigitCntWidth'(NumDigits - 1));
      last_step  = (step_ff == StepWidth'(CORDIC_STEPS - 1));
      sign_x     = first ? px_ff[CordicWidth-1] : sx_ff;
      sign_y     = first ? py_ff[CordicWidth-1] : sy_ff;
      dx         = shifted_digit(py_ff, sign_y, step_ff, digit_ff);
      dy         = shifted_digit(px_ff, sign_x, step_ff, digit_ff);
      tab_word   = atan_entry(step_ff)
                   >> ((IdxWidth+1)'(digit_ff) * (IdxWidth+1)'(DigitWidth));
      tab_digit  = tab_word[DigitWidth-1:0];
      cin_x      = first ? sign_y  : cx_ff;
      cin_y      = first ? ~sign_y : cy_ff;
      cin_z      = first ? sign_y  : cz_ff;
      sum_x      = {1'b0, px_ff[DigitWidth-1:0]} + {1'b0, dx ^ {DigitWidth{sign_y}}}
                   + (DigitWidth+1)'(cin_x);
      sum_y      = {1'b0, py_ff[DigitWidth-1:0]} + {1'b0, dy ^ {DigitWidth{~sign_y}}}
                   + (DigitWidth+1)'(cin_y);
      sum_z      = {1'b0, z_ff[DigitWidth-1:0]} + {1'b0, tab_digit ^ {DigitWidth{sign_y}}}
                   + (DigitWidth+1)'(cin_z);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CORDIC_IDLE: begin
            if (start) begin
               state_in = y_zero ? CORDIC_DONE : CORDIC_RUN;
            end
         end
         CORDIC_RUN: begin
            if (last_digit && last_step) begin
               state_in = CORDIC_DONE;
            end
         end
         CORDIC_DONE: begin
            state_in = CORDIC_IDLE;
         end
         default: begin
            state_in = CORDIC_IDLE;
         end
      endcase
   end

   always_comb begin
      status.busy = (state_ff != CORDIC_IDLE);
      status.done = (state_ff == CORDIC_DONE);
      load        = (state_ff == CORDIC_IDLE) && start;
      advance     = (state_ff == CORDIC_RUN);
   end

   always_comb begin
      step_in  = step_ff;
      digit_in = digit_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      z_in     = z_ff;
      if (load) begin
         step_in  = '0;
         digit_in = '0;
         px_in    = px_load;
         py_in    = py_load;
         z_in     = z_load;
      end else if (advance) begin
         px_in = {sum_x[DigitWidth-1:0], px_ff[CordicWidth-1:DigitWidth]};
         py_in = {sum_y[DigitWidth-1:0], py_ff[CordicWidth-1:DigitWidth]};
         z_in  = {sum_z[DigitWidth-1:0], z_ff[CordicWidth-1:DigitWidth]};
         if (last_digit) begin
            digit_in = '0;
            step_in  = step_ff + StepWidth'(1);
         end else begin
            digit_in = digit_ff + DigitCntWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORDIC_IDLE;
         step_ff  <= '0;
         digit_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         digit_ff <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      z_ff  <= z_in;
      if (advance) begin
         cx_ff <= sum_x[DigitWidth];
         cy_ff <= sum_y[DigitWidth];
         cz_ff <= sum_z[DigitWidth];
         if (first) begin
            sx_ff <= sign_x;
            sy_ff <= sign_y;
         end
      end
   end

   // truncate toward zero
   always_comb begin
      round_up = z_ff[CordicWidth-1] && (z_ff[AngleFrac-1:0] != '0);
      angle    = signed'(z_ff[AngleFrac+HeadWidth-1:AngleFrac] + HeadWidth'(round_up));
   end

endmodule

// ===== rtl/core/mha_average.sv =====
// Reference fold, group accumulation and bit-serial division of the heading sum.
module mha_average
   import mha_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        angle_valid,
   input  logic signed [HeadWidth-1:0] angle,
   input  logic [RefWidth-1:0]         reference_heading,
   input  logic                        reference_enabled,
   input  logic                        out_free,
   output avg_status_type              status,
   output logic signed [HeadWidth-1:0] heading
);

   localparam logic signed [DirWidth-1:0] DirFull = DirWidth'(FullCircle);
   localparam logic signed [DirWidth-1:0] DirHalf = DirWidth'(HalfCircle);

   avg_state_type state_ff, state_in;

   logic signed [SumWidth-1:0] sum_ff, sum_in;
   logic [CountWidth-1:0]      count_ff, count_in;
   logic [QuotCntWidth-1:0]    bit_ff, bit_in;
   logic [QuotWidth-1:0]       q_ff, q_in;
   logic [CountWidth-1:0]      rem_ff, rem_in;
   logic                       neg_ff, neg_in;

   logic signed [DirWidth-1:0] dir_raw, dir_ref, dir_wrap, dir;
   logic signed [SumWidth-1:0] sum_next, sum_abs;
   logic                       group_end, accumulate, dividing, last_bit;
   logic [CountWidth:0]        trial;
   logic                       trial_ge;
   logic [QuotWidth-1:0]       q_signed;

   always_comb begin
      dir_raw = DirWidth'(angle) + DirHalf;
      dir_ref = dir_raw - signed'(DirWidth'(reference_heading));
      if (dir_ref > DirFull) begin
         dir_wrap = dir_ref - DirFull;
      end else if (dir_ref < 0) begin
         dir_wrap = dir_ref + DirFull;
      end else begin
         dir_wrap = dir_ref;
      end
      if (!reference_enabled) begin
         dir = dir_raw;
      end else if (dir_wrap > DirHalf) begin
         dir = dir_wrap - DirFull;
      end else begin
         dir = dir_wrap;
      end
      sum_next  = sum_ff + SumWidth'(dir);
      sum_abs   = sum_next[SumWidth-1] ? -sum_next : sum_next;
      group_end = (count_ff == CountWidth'(AVERAGE_COUNT - 1));
      last_bit  = (bit_ff == QuotCntWidth'(QuotWidth - 1));
      trial     = {rem_ff, q_ff[QuotWidth-1]};
      trial_ge  = (trial >= (CountWidth+1)'(AVERAGE_COUNT));
      q_signed  = neg_ff ? -q_ff : q_ff;
      heading   = signed'(q_signed[HeadWidth-1:0]);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         AVG_IDLE: begin
            if (angle_valid && group_end) begin
               state_in = AVG_DIVIDE;
            end
         end
         AVG_DIVIDE: begin
            if (last_bit) begin
               state_in = AVG_HOLD;
            end
         end
         AVG_HOLD: begin
            if (out_free) begin
               state_in = AVG_IDLE;
            end
         end
         default: begin
            state_in = AVG_IDLE;
         end
      endcase
   end

   always_comb begin
      status.busy         = (state_ff != AVG_IDLE);
      status.result_valid = (state_ff == AVG_HOLD);
      accumulate          = (state_ff == AVG_IDLE) && angle_valid;
      dividing            = (state_ff == AVG_DIVIDE);
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      bit_in   = bit_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      if (accumulate) begin
         if (group_end) begin
            sum_in   = '0;
            count_in = '0;
            bit_in   = '0;
            q_in     = sum_abs[QuotWidth-1:0];
            rem_in   = '0;
            neg_in   = sum_next[SumWidth-1];
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + CountWidth'(1);
         end
      end else if (dividing) begin
         bit_in = bit_ff + QuotCntWidth'(1);
         q_in   = {q_ff[QuotWidth-2:0], trial_ge};
         rem_in = trial_ge ? CountWidth'(trial - (CountWidth+1)'(AVERAGE_COUNT))
                           : trial[CountWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AVG_IDLE;
         sum_ff   <= '0;
         count_ff <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         bit_ff   <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the magnetometer heading averager: stream driver, predictor, checker.
module tb_top;
   import mha_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [2*InWidth-1:0]     req_tdata = '0;   // mag_x [15:0], mag_y [31:16]
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [15:0]              rsp_tdata;        // heading_deg [9:0], zero [15:10]
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   logic [RefWidth-1:0]      ref_heading_cfg = '0;
   logic                     ref_enabled_cfg = 1'b0;
   longint                   atan_table [TableLen];
   logic [2*InWidth-1:0]     sample_q [$];
   logic [15:0]              heading_q [$];
   int                       pushed_count = 0;
   int                       accepted_count = 0;
   int                       group_sum = 0;
   int                       group_count = 0;
   int                       results_seen = 0;
   int                       errors = 0;
   int                       sender_idle_pct = 0;
   int                       receiver_idle_pct = 0;
   bit                       calm = 1'b0;
   int                       gap_left = 0;
   int                       stall_left = 0;

   magnetometer_heading_average dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // atan(1/n) in radians, 60 fraction bits, by its power series
   function automatic longint unsigned atan_series(input longint unsigned n);
      longint unsigned p, nn, acc, k, term;
      p = (64'd1 << 60) / n;
      nn = n * n;
      acc = 64'd0;
      k = 64'd0;
      while (p != 0) begin
         term = p / (2 * k + 1);
         if (k[0] == 1'b0) acc += term;
         else acc -= term;
         p = p / nn;
         k++;
      end
      return acc;
   endfunction

   function automatic longint to_scaled_degrees(input longint unsigned rad60);
      longint unsigned q48, d48;
      q48 = (rad60 + 64'd2048) >> 12;
      d48 = q48 * 64'd9000 / 64'd157;
      return longint'((d48 + (64'd1 << 23)) >> 24);
   endfunction

   function automatic longint vector_angle(input int num, input int den);
      longint px, py, z, t, dx, dy;
      px = longint'(den) * (longint'(1) << InShift);
      py = longint'(num) * (longint'(1) << InShift);
      z = 0;
      if (px < 0) begin
         t = px;
         if (py >= 0) begin
            px = py;
            py = -t;
            z = 2 * atan_table[0];
         end else begin
            px = -py;
            py = t;
            z = -2 * atan_table[0];
         end
      end
      for (int i = 0; i < CORDIC_STEPS && i < TableLen; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py >= 0) begin
            px += dx;
            py -= dy;
            z += atan_table[i];
         end else begin
            px -= dx;
            py += dy;
            z -= atan_table[i];
         end
      end
      return z;
   endfunction

   function automatic int compass_heading(input logic signed [15:0] x, input logic signed [15:0] y,
                                          input logic [RefWidth-1:0] ref_deg, input logic ref_on);
      int     dir, ref_val;
      longint z;
      ref_val = int'(ref_deg);
      if (y != 0) begin
         z = vector_angle(int'(x), int'(y));
         if (z >= 0) dir = int'(z >>> AngleFrac);
         else dir = -int'((-z) >>> AngleFrac);
      end else begin
         dir = (x < 0) ? HalfCircle : 0;
      end
      dir += HalfCircle;
      if (ref_on) begin
         dir -= ref_val;
         if (dir > FullCircle) dir -= FullCircle;
         else if (dir < 0) dir += FullCircle;
         if (dir > HalfCircle) dir -= FullCircle;
      end
      return dir;
   endfunction

   function automatic logic [2*InWidth-1:0] random_sample();
      logic [15:0] x, y;
      x = 16'($urandom);
      y = 16'($urandom);
      case ($urandom_range(0, 9))
         0: y = '0;
         1: x = '0;
         2: begin
            x = 16'($urandom_range(0, 6) - 3);
            y = 16'($urandom_range(0, 6) - 3);
         end
         3: begin
            x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            y = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         end
         4: y = $urandom_range(0, 1) ? 16'hffff : 16'h0001;
         default: ;
      endcase
      return {y, x};
   endfunction

   task automatic csr_write(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_REFERENCE_HEADING) ref_heading_cfg = value;
      else ref_enabled_cfg = value[0];
   endtask

   // hold until every request is taken and every heading has come, then let the block drain
   task automatic settle();
      @(posedge clock);
      while (accepted_count != pushed_count || heading_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic load_samples(input int count);
      for (int i = 0; i < count; i++) begin
         sample_q.push_back(random_sample());
         pushed_count++;
      end
   endtask

   always @(posedge clock) begin : sample_driver
      int dir, avg;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         gap_left <= 0;
         group_sum = 0;
         group_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            dir = compass_heading(req_tdata[15:0], req_tdata[31:16], ref_heading_cfg,
                                  ref_enabled_cfg);
            group_sum += dir;
            group_count++;
            accepted_count++;
            if (group_count == AVERAGE_COUNT) begin
               avg = group_sum / AVERAGE_COUNT;
               heading_q.push_back({6'b0, avg[HeadWidth-1:0]});
               group_sum = 0;
               group_count = 0;
            end
         end
         if (req_tvalid && !req_tready) begin
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (sample_q.size() > 0) begin
            if (!calm && $urandom_range(0, 99) < sender_idle_pct) begin
               gap_left <= $urandom_range(0, 4);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= sample_q.pop_front();
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : heading_monitor
      logic [15:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (heading_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected heading, expected none, actual %0d", $time,
                        $signed(rsp_tdata[HeadWidth-1:0]));
            end else begin
               want = heading_q.pop_front();
               results_seen++;
               if (rsp_tdata !== want) begin
                  errors++;
                  $display("%0t: heading mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                           $time, $signed(want[HeadWidth-1:0]), want,
                           $signed(rsp_tdata[HeadWidth-1:0]), rsp_tdata);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < receiver_idle_pct) begin
            stall_left <= $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int pairs [40];
      int settings [5][2];
      int random_total, phases, count, ref_val, en_val, idle_choice [3];
      pairs = '{32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768,
                0, 32767, 0, -32768, 32767, 0, -32768, 0, -1, 0, 1, 0,
                0, 0, 0, 1, 0, -1, 1, -1, -1, -1, 1, -32768, -1, -32768,
                -32768, -1, 32767, 1, -32768, 1};
      settings = '{'{0, 1}, '{359, 1}, '{511, 1}, '{360, 1}, '{180, 0}};
      idle_choice = '{0, 10, 35};
      atan_table[0] = to_scaled_degrees(4 * atan_series(64'd5) - atan_series(64'd239));
      for (int i = 1; i < TableLen; i++)
         atan_table[i] = to_scaled_degrees(atan_series(64'd1 << i));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 20; i++) begin
         sample_q.push_back({16'(pairs[2 * i + 1]), 16'(pairs[2 * i])});
         pushed_count++;
      end
      settle();

      random_total = 0;
      phases = 0;
      while (random_total < 1290) begin
         if (phases < 5) begin
            ref_val = settings[phases][0];
            en_val = settings[phases][1];
         end else begin
            ref_val = $urandom_range(0, 511);
            en_val = $urandom_range(0, 1);
         end
         if ($urandom_range(0, 1)) begin
            csr_write(REG_REFERENCE_HEADING, CsrDataWidth'(ref_val));
            csr_write(REG_REFERENCE_ENABLED, CsrDataWidth'(en_val));
         end else begin
            csr_write(REG_REFERENCE_ENABLED, CsrDataWidth'(en_val));
            csr_write(REG_REFERENCE_HEADING, CsrDataWidth'(ref_val));
         end
         sender_idle_pct = idle_choice[$urandom_range(0, 2)];
         receiver_idle_pct = idle_choice[$urandom_range(0, 2)];
         count = $urandom_range(30, 150);
         load_samples(count);
         random_total += count;
         phases++;
         settle();
      end

      csr_write(REG_REFERENCE_HEADING, CsrDataWidth'($urandom_range(0, 359)));
      csr_write(REG_REFERENCE_ENABLED, CsrDataWidth'(1));
      calm = 1'b1;
      load_samples(60);
      random_total += 60;
      settle();

      $display("Run covered %0d samples (%0d random) over %0d register settings;",
               pushed_count, random_total, phases + 2);
      $display("%0d averaged headings were checked against the predicted values.",
               results_seen);
      if (errors == 0 && heading_q.size() == 0) begin
         $display("PASS magnetometer_heading_average");
      end else begin
         $display("FAIL magnetometer_heading_average");
      end
      $finish;
   end

   initial begin : watchdog
      #8000000;
      $display("FAIL magnetometer_heading_average");
      $finish;
   end

endmodule
